// ===== rtl/binary_min_heap_priority_queue_assert.svh =====
// Assertion macros used by the heap queue datapath.
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Check that a condition holds at every edge outside reset.
`define BMHPQ_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define BMHPQ_ASSERT_IMPLY(lbl, clk, rst, trig, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

`endif

// ===== rtl/bmhpq_pkg.sv =====
package bmhpq_pkg;

   localparam int CAPACITY = 128;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      MODE_INSERT   = 2'd0,
      MODE_POP      = 2'd1,
      MODE_DECREASE = 2'd2
   } mode_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] prio;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_UP_CHK,
      S_UP_CMP,
      S_UP_WR,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_POP_LAST,
      S_DN_RD,
      S_DN_CMP,
      S_DN_WR,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic ins_start;
      logic ins_full;
      logic pop_start;
      logic dec_start;
      logic up_rd;
      logic up_move;
      logic ent_wr;
      logic scan_rd;
      logic scan_hit;
      logic scan_next;
      logic pop_last;
      logic dn_rd;
      logic dn_move;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       full;
      logic       empty;
      logic       one_left;
      logic       hole_zero;
      logic       up_less;
      logic       scan_end;
      logic       scan_hit;
      logic       dn_leaf;
      logic       dn_move;
   } sts_type;

endpackage

// ===== rtl/bmhpq_dpath.sv =====
`include "binary_min_heap_priority_queue_assert.svh"

module bmhpq_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  bmhpq_pkg::cmd_type        cmd,
   output bmhpq_pkg::sts_type        sts,
   input  logic [1:0]                req_mode,
   input  logic signed [31:0]        req_item_value,
   input  logic signed [31:0]        req_item_priority,
   output logic signed [31:0]        rsp_popped_value,
   output logic                      rsp_popped_valid,
   output logic signed [31:0]        rsp_top_value,
   output logic                      rsp_not_empty,
   output logic [7:0]                rsp_entry_count,
   output logic                      rsp_overflow
);
   import bmhpq_pkg::*;

   entry_type          mem [CAPACITY];
   entry_type          rd_a_ff, rd_b_ff;
   logic [IDX_W-1:0]   rd_a_addr, rd_b_addr;
   logic               wr_en;
   entry_type          wr_data;

   logic [CNT_W-1:0]   cnt_ff, scan_ff;
   logic [IDX_W-1:0]   hole_ff, parent_idx;
   logic [CNT_W:0]     left_idx, right_idx;
   logic               left_ok, right_ok, l_less, r_less;
   entry_type          ent_ff, key_ff, top_ff, cand, best;
   logic [1:0]         mode_ff;
   logic signed [31:0] pop_v_ff;
   logic               pvalid_ff, ovf_ff;

   // Heap index arithmetic
   assign parent_idx = IDX_W'((hole_ff - 1'b1) >> 1);
   assign left_idx   = (CNT_W + 1)'({hole_ff, 1'b1});
   assign right_idx  = left_idx + 1'b1;
   assign left_ok    = left_idx < {1'b0, cnt_ff};
   assign right_ok   = right_idx < {1'b0, cnt_ff};

   // Pick the smaller child, left on ties
   assign l_less = rd_a_ff.prio < ent_ff.prio;
   assign cand   = l_less ? rd_a_ff : ent_ff;
   assign r_less = right_ok && (rd_b_ff.prio < cand.prio);
   assign best   = r_less ? rd_b_ff : rd_a_ff;

   // Status back to the controller
   assign sts.mode      = mode_ff;
   assign sts.full      = cnt_ff >= CNT_W'(CAPACITY);
   assign sts.empty     = cnt_ff == '0;
   assign sts.one_left  = cnt_ff == CNT_W'(1);
   assign sts.hole_zero = hole_ff == '0;
   assign sts.up_less   = ent_ff.prio < rd_a_ff.prio;
   assign sts.scan_end  = scan_ff >= cnt_ff;
   assign sts.scan_hit  = (rd_a_ff.value == key_ff.value) && (key_ff.prio < rd_a_ff.prio);
   assign sts.dn_leaf   = !left_ok;
   assign sts.dn_move   = l_less || r_less;

   // Memory address and write selection
   always_comb begin
      rd_a_addr = IDX_W'(left_idx);
      if (cmd.up_rd) begin
         rd_a_addr = parent_idx;
      end else if (cmd.scan_rd) begin
         rd_a_addr = IDX_W'(scan_ff);
      end else if (cmd.pop_start) begin
         rd_a_addr = IDX_W'(cnt_ff - 1'b1);
      end
      rd_b_addr = IDX_W'(right_idx);
      wr_en     = cmd.up_move || cmd.dn_move || cmd.ent_wr;
      wr_data   = ent_ff;
      if (cmd.up_move) begin
         wr_data = rd_a_ff;
      end else if (cmd.dn_move) begin
         wr_data = best;
      end
   end

   // Heap store with two registered read ports; the right child port reads
   // only on a sift-down step
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[hole_ff] <= wr_data;
         if (hole_ff == '0) begin
            top_ff <= wr_data;
         end
      end
      rd_a_ff <= mem[rd_a_addr];
      if (cmd.dn_rd) begin
         rd_b_ff <= mem[rd_b_addr];
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         pvalid_ff <= 1'b0;
         ovf_ff    <= 1'b0;
      end else begin
         if (cmd.accept) begin
            key_ff    <= '{value: req_item_value, prio: req_item_priority};
            mode_ff   <= req_mode;
            pop_v_ff  <= '0;
            pvalid_ff <= 1'b0;
            ovf_ff    <= 1'b0;
         end
         if (cmd.ins_start) begin
            ent_ff  <= key_ff;
            hole_ff <= IDX_W'(cnt_ff);
            cnt_ff  <= cnt_ff + 1'b1;
         end
         if (cmd.ins_full) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.pop_start) begin
            pop_v_ff  <= top_ff.value;
            pvalid_ff <= 1'b1;
            cnt_ff    <= cnt_ff - 1'b1;
         end
         if (cmd.dec_start) begin
            scan_ff <= '0;
         end
         if (cmd.scan_hit) begin
            ent_ff  <= key_ff;
            hole_ff <= IDX_W'(scan_ff);
         end
         if (cmd.scan_next) begin
            scan_ff <= scan_ff + 1'b1;
         end
         if (cmd.up_move) begin
            hole_ff <= parent_idx;
         end
         if (cmd.pop_last) begin
            ent_ff  <= rd_a_ff;
            hole_ff <= '0;
         end
         if (cmd.dn_move) begin
            hole_ff <= r_less ? IDX_W'(right_idx) : IDX_W'(left_idx);
         end
      end
   end

   // Result word register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_popped_value <= pop_v_ff;
         rsp_popped_valid <= pvalid_ff;
         rsp_top_value    <= (cnt_ff != '0) ? top_ff.value : '0;
         rsp_not_empty    <= cnt_ff != '0;
         rsp_entry_count  <= 8'(cnt_ff);
         rsp_overflow     <= ovf_ff;
      end
   end

   `BMHPQ_ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(CAPACITY), "count over capacity")
   `BMHPQ_ASSERT_IMPLY(a_ovf_full, clock, reset, ovf_ff, cnt_ff == CNT_W'(CAPACITY), "overflow while not full")
   `BMHPQ_ASSERT_IMPLY(a_ovf_pop, clock, reset, ovf_ff, !pvalid_ff, "overflow and pop together")

endmodule

// ===== rtl/bmhpq_ctrl.sv =====
module bmhpq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  bmhpq_pkg::sts_type  sts,
   output bmhpq_pkg::cmd_type  cmd
);
   import bmhpq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // Hold state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequence one operation
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.mode)
               MODE_INSERT: begin
                  if (sts.full) begin
                     cmd.ins_full = 1'b1;
                     state_in     = S_FINISH;
                  end else begin
                     cmd.ins_start = 1'b1;
                     state_in      = S_UP_CHK;
                  end
               end
               MODE_POP: begin
                  if (sts.empty) begin
                     state_in = S_FINISH;
                  end else begin
                     cmd.pop_start = 1'b1;
                     state_in      = sts.one_left ? S_FINISH : S_POP_LAST;
                  end
               end
               MODE_DECREASE: begin
                  cmd.dec_start = 1'b1;
                  state_in      = S_SCAN_RD;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_UP_CHK: begin
            if (sts.hole_zero) begin
               state_in = S_UP_WR;
            end else begin
               cmd.up_rd = 1'b1;
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (sts.up_less) begin
               cmd.up_move = 1'b1;
               state_in    = S_UP_CHK;
            end else begin
               state_in = S_UP_WR;
            end
         end
         S_UP_WR: begin
            cmd.ent_wr = 1'b1;
            if (sts.mode == MODE_DECREASE) begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SCAN_RD: begin
            if (sts.scan_end) begin
               state_in = S_FINISH;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (sts.scan_hit) begin
               cmd.scan_hit = 1'b1;
               state_in     = S_UP_CHK;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_POP_LAST: begin
            cmd.pop_last = 1'b1;
            state_in     = S_DN_RD;
         end
         S_DN_RD: begin
            if (sts.dn_leaf) begin
               state_in = S_DN_WR;
            end else begin
               cmd.dn_rd = 1'b1;
               state_in  = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (sts.dn_move) begin
               cmd.dn_move = 1'b1;
               state_in    = S_DN_RD;
            end else begin
               state_in = S_DN_WR;
            end
         end
         S_DN_WR: begin
            cmd.ent_wr = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Advance result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

endmodule

// ===== rtl/binary_min_heap_priority_queue.sv =====
// Priority queue of 128 (value, priority) words kept as a binary min-heap in a
// two-read, one-write memory; the smallest signed priority is served first,
// ties on the way down go to the left child. Every request word (insert, pop,
// decrease) returns one response word with the popped value, the new top and
// the count; an insert into a full queue is dropped and flagged. One request
// runs at a time: insert sifts up one level per heap step and pop sifts down
// one level per heap step (at most 6 levels), each step waiting on the
// registered memory read; a pop of the last entry skips the sift-down.
// Decrease reads every held entry and runs a sift-up for each matching entry.
// The next request is taken while the previous response still waits.
module binary_min_heap_priority_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_item_value,
   input  logic signed [31:0] req_item_priority,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_popped_value,
   output logic               rsp_popped_valid,
   output logic signed [31:0] rsp_top_value,
   output logic               rsp_not_empty,
   output logic [7:0]         rsp_entry_count,
   output logic               rsp_overflow
);
   import bmhpq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bmhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bmhpq_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_mode          (req_mode),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_popped_value  (rsp_popped_value),
      .rsp_popped_valid  (rsp_popped_valid),
      .rsp_top_value     (rsp_top_value),
      .rsp_not_empty     (rsp_not_empty),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_overflow      (rsp_overflow)
   );

endmodule
